/* rtl/qbal_pkg.sv */
`default_nettype none

package qbal_pkg;

    localparam int NODE_COUNT = 10;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int COORD_W = 32;
    localparam int T_W = 17;
    localparam int LEN_W = 41;

    localparam int H_W = T_W + 1;
    localparam int M_W = T_W + 1;
    localparam int D0_W = COORD_W + 2;
    localparam int DD_W = COORD_W + 3;

    localparam int B_W = 39;
    localparam int A_W = 37;
    localparam int N_W = 2 * A_W + 1;
    localparam int ROOT_W = 38;
    localparam int RAD_W = 2 * ROOT_W;

    localparam int NODE_LAT = 7;

    localparam longint unsigned DEC_SCALE = 64'd1000000000;

    localparam longint unsigned WT_DEC [NODE_COUNT/2] = '{
        64'd295524225, 64'd269266719, 64'd219086363, 64'd149451349, 64'd66671344
    };
    localparam longint unsigned AB_DEC [NODE_COUNT/2] = '{
        64'd148874339, 64'd433395394, 64'd679409568, 64'd865063367, 64'd973906529
    };

    function automatic longint unsigned to_fixed(longint unsigned dec, int fb);
        return ((dec << fb) + DEC_SCALE / 2) / DEC_SCALE;
    endfunction

    typedef struct packed {
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic [T_W-1:0]            t_start;
        logic [T_W-1:0]            t_end;
    } qbal_in_t;

    typedef struct packed {
        logic signed [LEN_W-1:0] arc_length;
        logic                    saturated;
    } qbal_out_t;

    typedef struct packed {
        logic signed [H_W-1:0]  h;
        logic [M_W-1:0]         m;
        logic signed [D0_W-1:0] d0x;
        logic signed [D0_W-1:0] d0y;
        logic signed [DD_W-1:0] ddx;
        logic signed [DD_W-1:0] ddy;
    } seg_t;

endpackage

`default_nettype wire

/* rtl/qbal_node.sv */
`default_nettype none

module qbal_node
    import qbal_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int LANE = 0
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire seg_t           seg,
    output logic                out_valid,
    output logic [N_W-1:0]      norm_sq
);

    localparam int X_W = FRACTION_BITS + 1;
    localparam logic [X_W-1:0] X_FIX = X_W'(to_fixed(AB_DEC[LANE/2], FRACTION_BITS));
    localparam bit NEG = (LANE % 2 == 0);
    localparam int HX_W = H_W + X_W + 1;
    localparam int US_W = M_W + FRACTION_BITS + 2;
    localparam int U_W = FRACTION_BITS + 3;
    localparam int P_W = U_W + DD_W;
    localparam int BS_W = P_W + 1;
    localparam int LO_W = 19;
    localparam int HI_W = A_W - LO_W;

    logic [NODE_LAT-1:0] valid_reg;

    // stage 1: offset of node from interval midpoint
    logic signed [HX_W-1:0] hx_reg;
    logic [M_W-1:0]         m1_reg;
    logic signed [D0_W-1:0] d0x1_reg, d0y1_reg;
    logic signed [DD_W-1:0] ddx1_reg, ddy1_reg;

    // stage 2: node parameter
    logic signed [US_W-1:0] usum, urnd;
    logic signed [U_W-1:0]  u_reg;
    logic signed [D0_W-1:0] d0x2_reg, d0y2_reg;
    logic signed [DD_W-1:0] ddx2_reg, ddy2_reg;

    // stage 3: slope products
    logic signed [P_W-1:0]  px_reg, py_reg;
    logic signed [D0_W-1:0] d0x3_reg, d0y3_reg;

    // stage 4: derivative
    logic signed [BS_W-1:0] bsx, bsy, brx, bry;
    logic signed [B_W-1:0]  bx_reg, by_reg;

    // stage 5: magnitudes
    logic [A_W-1:0] ax_reg, ay_reg;

    // stage 6: partial squares
    logic [2*HI_W-1:0]      xhh_reg, yhh_reg;
    logic [HI_W+LO_W-1:0]   xhl_reg, yhl_reg;
    logic [2*LO_W-1:0]      xll_reg, yll_reg;

    logic [N_W-1:0] norm_sq_reg;

    always_comb
    begin
        usum = (NEG ? -US_W'(hx_reg) : US_W'(hx_reg))
             + (US_W'(signed'({1'b0, m1_reg})) <<< FRACTION_BITS);
        urnd = usum + US_W'(65536) - US_W'(usum[US_W-1]);

        bsx = (BS_W'(d0x3_reg) <<< FRACTION_BITS) + BS_W'(px_reg);
        bsy = (BS_W'(d0y3_reg) <<< FRACTION_BITS) + BS_W'(py_reg);
        brx = bsx + (BS_W'(1) <<< (FRACTION_BITS - 1)) - BS_W'(bsx[BS_W-1]);
        bry = bsy + (BS_W'(1) <<< (FRACTION_BITS - 1)) - BS_W'(bsy[BS_W-1]);
    end

    always_ff @(posedge clk)
    begin
        hx_reg   <= HX_W'(seg.h * signed'({1'b0, X_FIX}));
        m1_reg   <= seg.m;
        d0x1_reg <= seg.d0x;
        d0y1_reg <= seg.d0y;
        ddx1_reg <= seg.ddx;
        ddy1_reg <= seg.ddy;

        u_reg    <= U_W'(urnd >>> 17);
        d0x2_reg <= d0x1_reg;
        d0y2_reg <= d0y1_reg;
        ddx2_reg <= ddx1_reg;
        ddy2_reg <= ddy1_reg;

        px_reg   <= P_W'(u_reg * ddx2_reg);
        py_reg   <= P_W'(u_reg * ddy2_reg);
        d0x3_reg <= d0x2_reg;
        d0y3_reg <= d0y2_reg;

        bx_reg   <= B_W'(brx >>> FRACTION_BITS);
        by_reg   <= B_W'(bry >>> FRACTION_BITS);

        ax_reg   <= A_W'(bx_reg[B_W-1] ? -bx_reg : bx_reg);
        ay_reg   <= A_W'(by_reg[B_W-1] ? -by_reg : by_reg);

        xhh_reg  <= ax_reg[A_W-1:LO_W] * ax_reg[A_W-1:LO_W];
        xhl_reg  <= ax_reg[A_W-1:LO_W] * ax_reg[LO_W-1:0];
        xll_reg  <= ax_reg[LO_W-1:0] * ax_reg[LO_W-1:0];
        yhh_reg  <= ay_reg[A_W-1:LO_W] * ay_reg[A_W-1:LO_W];
        yhl_reg  <= ay_reg[A_W-1:LO_W] * ay_reg[LO_W-1:0];
        yll_reg  <= ay_reg[LO_W-1:0] * ay_reg[LO_W-1:0];

        norm_sq_reg <= (N_W'(xhh_reg) << (2*LO_W)) + (N_W'(xhl_reg) << (LO_W+1))
                     + N_W'(xll_reg)
                     + (N_W'(yhh_reg) << (2*LO_W)) + (N_W'(yhl_reg) << (LO_W+1))
                     + N_W'(yll_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[NODE_LAT-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[NODE_LAT-1];
    assign norm_sq   = norm_sq_reg;

endmodule

`default_nettype wire

/* rtl/qbal_sqrt.sv */
`default_nettype none

module qbal_sqrt
    import qbal_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [N_W-1:0]    radicand,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      root
);

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  rem_reg  [ROOT_W-1];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [ROOT_W-1:0] valid_reg;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        logic [REM_W-1:0]  rem_in, rem_sh, trial, rem_next;
        logic [ROOT_W-1:0] root_in, root_next;
        logic [RAD_W-1:0]  rad_in;
        logic              valid_in;

        if (k == 0)
        begin : g_first
            assign rem_in   = '0;
            assign root_in  = '0;
            assign rad_in   = RAD_W'(radicand);
            assign valid_in = in_valid;
        end
        else
        begin : g_next
            assign rem_in   = rem_reg[k-1];
            assign root_in  = root_reg[k-1];
            assign rad_in   = rad_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        // one root bit per stage
        always_comb
        begin
            rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
            trial  = {root_in, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            root_reg[k] <= root_next;
        end

        if (k < ROOT_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
                rad_reg[k] <= {rad_in[RAD_W-3:0], 2'b00};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

/* rtl/qbal_sum.sv */
`default_nettype none

module qbal_sum
    import qbal_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [ROOT_W-1:0]     norm [NODE_COUNT],
    input  wire logic signed [H_W-1:0] h,
    output logic                       done,
    output qbal_out_t                  result
);

    localparam int X_W = FRACTION_BITS + 1;
    localparam int LO_W = 19;
    localparam int HI_W = ROOT_W - LO_W;
    localparam int WN_W = X_W + ROOT_W;
    localparam int TOT_W = WN_W + 4;
    localparam int S_W = TOT_W - FRACTION_BITS;
    localparam int HM_W = H_W - 1;
    localparam int SL_W = 22;
    localparam int SH_W = S_W - SL_W;
    localparam int PR_W = HM_W + S_W;
    localparam int MAG_W = PR_W - 16;
    localparam int STAGES = 10;

    localparam logic [MAG_W-1:0] POS_MAX = (MAG_W'(1) << (LEN_W - 1)) - MAG_W'(1);
    localparam logic [MAG_W-1:0] NEG_MAX = MAG_W'(1) << (LEN_W - 1);

    logic [STAGES-1:0] valid_reg;

    logic [X_W+LO_W-1:0] lo_reg [NODE_COUNT];
    logic [X_W+HI_W-1:0] hi_reg [NODE_COUNT];
    logic [WN_W-1:0]     wn_reg [NODE_COUNT];
    logic [WN_W:0]       ps_reg [NODE_COUNT/2];
    logic [WN_W+1:0]     ta_reg, tb_reg, tc_reg;
    logic [TOT_W-1:0]    total_reg;
    logic [S_W-1:0]      s16_reg;
    logic [HM_W+SL_W-1:0] pm_lo_reg;
    logic [HM_W+SH_W-1:0] pm_hi_reg;
    logic [PR_W-1:0]     prod_reg;
    logic [MAG_W-1:0]    mag_reg;

    logic signed [H_W-1:0] h1_reg, h2_reg, h3_reg, h4_reg, h5_reg;
    logic [HM_W-1:0]       hmag6_reg;
    logic                  neg6_reg, neg7_reg, neg8_reg, neg9_reg;

    logic [TOT_W-1:0]  total_rnd;
    logic [PR_W:0]     prod_rnd;
    logic [MAG_W-1:0]  lim, mag_clip;
    logic              sat;
    qbal_out_t         result_next, result_reg;

    for (genvar i = 0; i < NODE_COUNT; i++)
    begin : g_lane
        localparam logic [X_W-1:0] W_FIX = X_W'(to_fixed(WT_DEC[i/2], FRACTION_BITS));

        always_ff @(posedge clk)
        begin
            lo_reg[i] <= W_FIX * norm[i][LO_W-1:0];
            hi_reg[i] <= W_FIX * norm[i][ROOT_W-1:LO_W];
            wn_reg[i] <= (WN_W'(hi_reg[i]) << LO_W) + WN_W'(lo_reg[i]);
        end
    end

    for (genvar j = 0; j < NODE_COUNT/2; j++)
    begin : g_pair
        always_ff @(posedge clk)
        begin
            ps_reg[j] <= (WN_W+1)'(wn_reg[2*j]) + (WN_W+1)'(wn_reg[2*j+1]);
        end
    end

    always_comb
    begin
        total_rnd = total_reg + (TOT_W'(1) << (FRACTION_BITS - 1));
        prod_rnd  = (PR_W+1)'(prod_reg) + (PR_W+1)'(65536);

        lim      = neg9_reg ? NEG_MAX : POS_MAX;
        sat      = mag_reg > lim;
        mag_clip = sat ? lim : mag_reg;
        result_next.arc_length = neg9_reg ? -mag_clip[LEN_W-1:0] : mag_clip[LEN_W-1:0];
        result_next.saturated  = sat;
    end

    always_ff @(posedge clk)
    begin
        h1_reg <= h;
        h2_reg <= h1_reg;
        h3_reg <= h2_reg;
        h4_reg <= h3_reg;
        h5_reg <= h4_reg;

        ta_reg <= (WN_W+2)'(ps_reg[0]) + (WN_W+2)'(ps_reg[1]);
        tb_reg <= (WN_W+2)'(ps_reg[2]) + (WN_W+2)'(ps_reg[3]);
        tc_reg <= (WN_W+2)'(ps_reg[4]);

        total_reg <= TOT_W'(ta_reg) + TOT_W'(tb_reg) + TOT_W'(tc_reg);

        s16_reg   <= S_W'(total_rnd >> FRACTION_BITS);
        hmag6_reg <= HM_W'(h5_reg[H_W-1] ? -h5_reg : h5_reg);
        neg6_reg  <= h5_reg[H_W-1];

        pm_lo_reg <= hmag6_reg * s16_reg[SL_W-1:0];
        pm_hi_reg <= hmag6_reg * s16_reg[S_W-1:SL_W];
        neg7_reg  <= neg6_reg;

        prod_reg  <= (PR_W'(pm_hi_reg) << SL_W) + PR_W'(pm_lo_reg);
        neg8_reg  <= neg7_reg;

        mag_reg   <= MAG_W'(prod_rnd >> 17);
        neg9_reg  <= neg8_reg;

        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    assign done   = valid_reg[STAGES-1];
    assign result = result_reg;

endmodule

`default_nettype wire

/* rtl/quadratic_bezier_arc_length_unit.sv */
// Arc length of a quadratic Bezier segment over [t_start, t_end] by 10-point
// Gauss-Legendre quadrature. The unit is fully pipelined: busy stays low, a new
// segment may be started every cycle, and done pulses for one cycle with the
// result once the segment has passed 1 input stage, 7 node stages, 38
// square-root stages, one per root bit, and 10 weighting, summing and scaling
// stages. Ten node lanes run side by side. The receiver must take each
// result in the cycle it is shown.
`default_nettype none

module quadratic_bezier_arc_length_unit
    import qbal_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire qbal_in_t  segment,
    output logic           done,
    output qbal_out_t      result
);

    localparam int H_DLY = NODE_LAT + ROOT_W;

    seg_t seg_reg, seg_next;
    logic seg_valid_reg;

    logic signed [COORD_W:0]   d0x_half, d0y_half;
    logic signed [COORD_W+1:0] secx, secy;

    logic [NODE_COUNT-1:0] node_valid, root_valid;
    logic [N_W-1:0]        norm_sq [NODE_COUNT];
    logic [ROOT_W-1:0]     norm    [NODE_COUNT];

    logic signed [H_W-1:0] h_dly_reg [H_DLY];

    always_comb
    begin
        d0x_half = (COORD_W+1)'(segment.p1_x) - (COORD_W+1)'(segment.p0_x);
        d0y_half = (COORD_W+1)'(segment.p1_y) - (COORD_W+1)'(segment.p0_y);
        secx = (COORD_W+2)'(segment.p2_x) + (COORD_W+2)'(segment.p0_x)
             - ((COORD_W+2)'(segment.p1_x) <<< 1);
        secy = (COORD_W+2)'(segment.p2_y) + (COORD_W+2)'(segment.p0_y)
             - ((COORD_W+2)'(segment.p1_y) <<< 1);

        seg_next.h   = H_W'({1'b0, segment.t_end}) - H_W'({1'b0, segment.t_start});
        seg_next.m   = M_W'({1'b0, segment.t_end}) + M_W'({1'b0, segment.t_start});
        seg_next.d0x = {d0x_half, 1'b0};
        seg_next.d0y = {d0y_half, 1'b0};
        seg_next.ddx = {secx, 1'b0};
        seg_next.ddy = {secy, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            seg_valid_reg <= start && !busy;
        end
    end

    // interval length follows the node lanes for the final scaling
    for (genvar d = 0; d < H_DLY; d++)
    begin : g_hdly
        if (d == 0)
        begin : g_head
            always_ff @(posedge clk)
            begin
                h_dly_reg[d] <= seg_reg.h;
            end
        end
        else
        begin : g_tail
            always_ff @(posedge clk)
            begin
                h_dly_reg[d] <= h_dly_reg[d-1];
            end
        end
    end

    for (genvar i = 0; i < NODE_COUNT; i++)
    begin : g_lane
        qbal_node #(
            .FRACTION_BITS (FRACTION_BITS),
            .LANE          (i)
        ) u_node (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (seg_valid_reg),
            .seg       (seg_reg),
            .out_valid (node_valid[i]),
            .norm_sq   (norm_sq[i])
        );

        qbal_sqrt u_sqrt (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (node_valid[i]),
            .radicand  (norm_sq[i]),
            .out_valid (root_valid[i]),
            .root      (norm[i])
        );
    end

    qbal_sum #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (&root_valid),
        .norm     (norm),
        .h        (h_dly_reg[H_DLY-1]),
        .done     (done),
        .result   (result)
    );

    assign busy = 1'b0;

endmodule

`default_nettype wire

/* dv/tb_quadratic_bezier_arc_length_unit.sv */
`timescale 1ns / 100ps

module tb_quadratic_bezier_arc_length_unit;
    import qbal_pkg::*;

    localparam int FB = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;

    localparam longint unsigned WEIGHT_DEC [5] = '{
        64'd295524225, 64'd269266719, 64'd219086363, 64'd149451349, 64'd66671344
    };
    localparam longint unsigned NODE_DEC [5] = '{
        64'd148874339, 64'd433395394, 64'd679409568, 64'd865063367, 64'd973906529
    };

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    qbal_in_t  segment;
    logic      done;
    qbal_out_t result;

    qbal_out_t expected_lengths [$];
    int        error_count;
    int        idle_cycles;
    bit        allow_gaps;

    quadratic_bezier_arc_length_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .segment (segment),
        .done    (done),
        .result  (result)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic longint round_half_away(longint v, int s);
        longint unsigned mag;
        mag = v < 0 ? -v : v;
        mag = (mag + (64'd1 << (s - 1))) >> s;
        return v < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint unsigned floor_hypot(longint unsigned ax, longint unsigned ay);
        logic [127:0] radicand;
        logic [127:0] trial;
        longint unsigned root;
        radicand = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        root = 0;
        for (int b = 38; b >= 0; b--)
        begin
            trial = 128'(root | (64'd1 << b));
            if (trial * trial <= radicand)
                root = root | (64'd1 << b);
        end
        return root;
    endfunction

    function automatic qbal_out_t quadrature_length(qbal_in_t s);
        qbal_out_t       r;
        longint          t0, t1, h, m, d0x, d0y, ddx, ddy, u, bx, by, x, len;
        longint unsigned w, sum, s16, hmag, mag;
        longint unsigned pos_max, neg_max;
        t0 = longint'(s.t_start);
        t1 = longint'(s.t_end);
        h = t1 - t0;
        m = t0 + t1;
        d0x = 2 * (longint'(s.p1_x) - longint'(s.p0_x));
        d0y = 2 * (longint'(s.p1_y) - longint'(s.p0_y));
        ddx = 2 * (longint'(s.p2_x) - longint'(s.p1_x)) - d0x;
        ddy = 2 * (longint'(s.p2_y) - longint'(s.p1_y)) - d0y;
        sum = 0;
        for (int i = 0; i < 10; i++)
        begin
            x = longint'(((NODE_DEC[i/2] << FB) + 64'd500000000) / 64'd1000000000);
            w = ((WEIGHT_DEC[i/2] << FB) + 64'd500000000) / 64'd1000000000;
            if (i % 2 == 0)
                x = -x;
            u = round_half_away(h * x + m * (longint'(1) << FB), 17);
            bx = round_half_away(d0x * (longint'(1) << FB) + u * ddx, FB);
            by = round_half_away(d0y * (longint'(1) << FB) + u * ddy, FB);
            sum += w * floor_hypot(bx < 0 ? -bx : bx, by < 0 ? -by : by);
        end
        s16 = (sum + (64'd1 << (FB - 1))) >> FB;
        hmag = h < 0 ? -h : h;
        mag = (hmag * s16 + (64'd1 << 16)) >> 17;
        pos_max = (64'd1 << (LEN_W - 1)) - 1;
        neg_max = 64'd1 << (LEN_W - 1);
        r.saturated = 1'b0;
        if (h < 0)
        begin
            if (mag > neg_max)
            begin
                mag = neg_max;
                r.saturated = 1'b1;
            end
            len = -longint'(mag);
        end
        else
        begin
            if (mag > pos_max)
            begin
                mag = pos_max;
                r.saturated = 1'b1;
            end
            len = longint'(mag);
        end
        r.arc_length = len[LEN_W-1:0];
        return r;
    endfunction

    // transaction tracking, result checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected_lengths = {expected_lengths, quadrature_length(segment)};
            if (done)
            begin
                if (expected_lengths.size() == 0)
                begin
                    $error("unexpected result: arc_length=%0d saturated=%0b",
                           result.arc_length, result.saturated);
                    error_count++;
                end
                else
                begin
                    qbal_out_t e;
                    e = expected_lengths.pop_front();
                    if (result.arc_length !== e.arc_length)
                    begin
                        $error("arc_length: expected %0d, actual %0d",
                               e.arc_length, result.arc_length);
                        error_count++;
                    end
                    if (result.saturated !== e.saturated)
                    begin
                        $error("saturated: expected %0b, actual %0b",
                               e.saturated, result.saturated);
                        error_count++;
                    end
                end
            end
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** quadratic_bezier_arc_length_unit: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_segment(qbal_in_t s);
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        start <= 1'b1;
        segment <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause_sender();
        start <= 1'b0;
        @(posedge clk);
        while (expected_lengths.size() != 0)
            @(posedge clk);
    endtask

    function automatic qbal_in_t make_segment(int c0x, int c0y, int c1x, int c1y,
                                              int c2x, int c2y, int ts, int te);
        qbal_in_t s;
        s.p0_x = c0x;
        s.p0_y = c0y;
        s.p1_x = c1x;
        s.p1_y = c1y;
        s.p2_x = c2x;
        s.p2_y = c2y;
        s.t_start = ts[T_W-1:0];
        s.t_end = te[T_W-1:0];
        return s;
    endfunction

    function automatic int random_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            2: return $signed($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000;
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    function automatic int random_param();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 131071);
            1: return $urandom_range(0, 1) ? 65536 : 0;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    task automatic test_directed();
        send_segment(make_segment(0, 0, 0, 0, 0, 0, 0, 65536));
        send_segment(make_segment(0, 0, 32'h10000, 0, 32'h20000, 0, 0, 65536));
        send_segment(make_segment(0, 0, 32'h10000, 0, 32'h20000, 0, 65536, 0));
        send_segment(make_segment(0, 0, 32'h10000, 32'h20000, 32'h30000, 0, 16384, 49152));
        send_segment(make_segment(0, 0, 32'h10000, 32'h20000, 32'h30000, 0, 49152, 16384));
        send_segment(make_segment(5, 7, 9, 11, 13, 17, 30000, 30000));
        send_segment(make_segment(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                  32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 0, 65536));
        send_segment(make_segment(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 131071));
        send_segment(make_segment(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 131071, 0));
        send_segment(make_segment(0, 0, 32'h10000, 32'h10000, 32'h20000, 0, 65536, 131071));
        send_segment(make_segment(0, 0, 32'h10000, 32'h10000, 32'h20000, 0, 131071, 65536));
        send_segment(make_segment(-1, -1, -1, -1, -1, -1, 0, 131071));
        send_segment(make_segment(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0,
                                  0, 131071));
        send_segment(make_segment(0, 32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0, 32'sh8000_0000,
                                  131071, 0));
        send_segment(make_segment(1, 1, 2, 2, 3, 3, 1, 0));
        send_segment(make_segment(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                                  32'hF0F0_F0F0, 32'h5555_5555, 32'hAAAA_AAAA, 0, 1));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_segment(make_segment(random_coord(), random_coord(), random_coord(),
                                      random_coord(), random_coord(), random_coord(),
                                      random_param(), random_param()));
    endtask

    task automatic test_pause_until_drained();
        test_random(20);
        pause_sender();
        test_random(20);
    endtask

    task automatic test_back_to_back();
        allow_gaps = 1'b0;
        test_random(120);
        start <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        segment = '0;
        error_count = 0;
        idle_cycles = 0;
        allow_gaps = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(340);
        test_pause_until_drained();
        test_back_to_back();
        @(posedge clk);
        while (expected_lengths.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("** quadratic_bezier_arc_length_unit: PASSED **");
        else
            $display("** quadratic_bezier_arc_length_unit: FAILED **");
        $finish;
    end

endmodule
